FILE: hdl/ttst_pkg.sv
// shared types, codes and sizes for the tick task scheduler table
`default_nettype none
package ttst_pkg;

    localparam int SLOTS       = 8;
    localparam int RUN_LIMIT   = 3;
    localparam int MAX_RESULTS = 8;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int ACT_W   = 3;
    localparam int SEL_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int RUNS_W  = 2;
    localparam int RUN_CAP = (RUN_LIMIT < 3) ? RUN_LIMIT : 3;

    localparam logic [ACT_W-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOOKUP   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_TICK     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DISPATCH = 3'd4;

    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PREEMPT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COOP    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] tag;
        logic              overrun;
    } result_t;

    typedef struct packed {
        logic             load;
        logic             step;
        logic [IDX_W-1:0] idx;
        logic             reply;
        logic             flush;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit;
        logic pend_valid;
        logic out_free;
        logic needs_reply;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: hdl/ttst_ctrl.sv
// controller state machine: request intake, slot walk, reply and final flush
`default_nettype none
module ttst_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire ttst_pkg::dp_status_t sts,
    output ttst_pkg::ctrl_cmd_t     cmd
);
    import ttst_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_REPLY, ST_FLUSH} state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             step_ok;

    assign step_ok = !sts.emit || !sts.pend_valid || sts.out_free;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (step_ok) begin
                    cmd.step = 1'b1;
                    if (idx_reg == IDX_W'(SLOTS - 1)) begin
                        state_next = sts.needs_reply ? ST_REPLY : ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_REPLY: begin
                cmd.reply  = 1'b1;
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_flush_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> sts.pend_valid && sts.out_free)
        else $error("flush without a pending result");
    a_reply_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reply |-> !sts.pend_valid)
        else $error("reply would overwrite a pending result");
    a_step_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step && sts.emit && sts.pend_valid |-> sts.out_free)
        else $error("emission while output register is blocked");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_tready)
        else $error("new request taken while one is in progress");

endmodule
`default_nettype wire

FILE: hdl/ttst_datapath.sv
// datapath: slot table, latched request, per-slot update, pending and output registers
`default_nettype none
module ttst_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ttst_pkg::ctrl_cmd_t         cmd,
    output ttst_pkg::dp_status_t             sts,
    input  wire logic [ttst_pkg::ACT_W-1:0]  req_action,
    input  wire logic [ttst_pkg::SEL_W-1:0]  req_slot_select,
    input  wire logic [ttst_pkg::BYTE_W-1:0] req_first_delay,
    input  wire logic [ttst_pkg::BYTE_W-1:0] req_repeat_period,
    input  wire logic                        req_cooperative,
    input  wire logic [ttst_pkg::BYTE_W-1:0] req_task_tag,
    output ttst_pkg::result_t                out_result,
    output logic                             out_last,
    output logic                             out_valid,
    input  wire logic                        out_ready
);
    import ttst_pkg::*;

    logic                valid_reg [SLOTS];
    logic                coop_reg  [SLOTS];
    logic [BYTE_W-1:0]   tag_reg   [SLOTS];
    logic [BYTE_W-1:0]   cd_reg    [SLOTS];
    logic [BYTE_W-1:0]   per_reg   [SLOTS];
    logic [RUNS_W-1:0]   runs_reg  [SLOTS];

    logic [ACT_W-1:0]    act_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [BYTE_W-1:0]   delay_reg;
    logic [BYTE_W-1:0]   period_reg;
    logic                coop_in_reg;
    logic [BYTE_W-1:0]   tag_in_reg;

    logic                found_reg, found_next;
    logic [IDX_W-1:0]    found_idx_reg, found_idx_next;
    logic [CNT_W-1:0]    n_reg;

    logic                pend_valid_reg;
    result_t             pend_reg;
    logic                out_valid_reg;
    result_t             out_reg;
    logic                out_last_reg;

    logic                cur_valid, cur_coop;
    logic [BYTE_W-1:0]   cur_tag, cur_cd, cur_per, cd_dec;
    logic [RUNS_W-1:0]   cur_runs;
    logic                nv_valid, nv_coop;
    logic [BYTE_W-1:0]   nv_tag, nv_cd, nv_per;
    logic [RUNS_W-1:0]   nv_runs;
    logic                emit, room, xfer, out_free;
    result_t             emit_res, reply_res;

    assign cur_valid = valid_reg[cmd.idx];
    assign cur_coop  = coop_reg[cmd.idx];
    assign cur_tag   = tag_reg[cmd.idx];
    assign cur_cd    = cd_reg[cmd.idx];
    assign cur_per   = per_reg[cmd.idx];
    assign cur_runs  = runs_reg[cmd.idx];
    assign cd_dec    = (cur_cd != '0) ? cur_cd - 1'b1 : '0;
    assign room      = n_reg < CNT_W'(MAX_RESULTS);

    always_comb begin
        nv_valid       = cur_valid;
        nv_coop        = cur_coop;
        nv_tag         = cur_tag;
        nv_cd          = cur_cd;
        nv_per         = cur_per;
        nv_runs        = cur_runs;
        emit           = 1'b0;
        emit_res       = '0;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        case (act_reg)
            ACT_ADD: begin
                if (!found_reg && !cur_valid) begin
                    nv_valid       = 1'b1;
                    nv_coop        = coop_in_reg;
                    nv_tag         = tag_in_reg;
                    nv_per         = period_reg;
                    nv_runs        = (delay_reg == '0) ? RUNS_W'(1) : '0;
                    nv_cd          = (delay_reg == '0) ? period_reg : delay_reg;
                    found_next     = 1'b1;
                    found_idx_next = cmd.idx;
                end
            end
            ACT_DELETE: begin
                if (int'(sel_reg) == int'(cmd.idx) && cur_valid) begin
                    nv_valid = 1'b0;
                end
            end
            ACT_LOOKUP: begin
                if (!found_reg && cur_valid && cur_tag == tag_in_reg) begin
                    found_next     = 1'b1;
                    found_idx_next = cmd.idx;
                end
            end
            ACT_TICK: begin
                if (cur_valid) begin
                    nv_cd = cd_dec;
                    if (cd_dec == '0) begin
                        if (cur_coop) begin
                            if (cur_runs < RUNS_W'(RUN_CAP)) begin
                                nv_runs = cur_runs + 1'b1;
                            end
                            if (cur_per != '0) begin
                                nv_cd = cur_per;
                            end
                        end else begin
                            emit             = room;
                            emit_res.kind    = KIND_PREEMPT;
                            emit_res.slot    = SLOT_W'(cmd.idx);
                            emit_res.tag     = cur_tag;
                            if (cur_per == '0) begin
                                nv_valid = 1'b0;
                            end else begin
                                nv_cd = cur_per;
                            end
                        end
                    end
                end
            end
            ACT_DISPATCH: begin
                if (room && cur_valid && cur_runs != '0) begin
                    emit             = 1'b1;
                    emit_res.kind    = KIND_COOP;
                    emit_res.slot    = SLOT_W'(cmd.idx);
                    emit_res.tag     = cur_tag;
                    emit_res.overrun = cur_runs > RUNS_W'(1);
                    nv_runs          = '0;
                    if (cur_per == '0) begin
                        nv_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        reply_res      = '0;
        reply_res.kind = (act_reg == ACT_ADD) ? KIND_ADD : KIND_LOOKUP;
        reply_res.slot = found_reg ? SLOT_W'(found_idx_reg) : SLOT_W'(SLOTS);
    end

    assign out_free = !out_valid_reg || out_ready;
    assign xfer     = (cmd.step && emit && pend_valid_reg) || cmd.flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.step) begin
            valid_reg[cmd.idx] <= nv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            coop_reg[cmd.idx] <= nv_coop;
            tag_reg[cmd.idx]  <= nv_tag;
            cd_reg[cmd.idx]   <= nv_cd;
            per_reg[cmd.idx]  <= nv_per;
            runs_reg[cmd.idx] <= nv_runs;
        end
        if (cmd.load) begin
            act_reg     <= req_action;
            sel_reg     <= req_slot_select;
            delay_reg   <= req_first_delay;
            period_reg  <= req_repeat_period;
            coop_in_reg <= req_cooperative;
            tag_in_reg  <= req_task_tag;
        end
        if (cmd.step) begin
            found_idx_reg <= found_idx_next;
        end
        if (cmd.step && emit) begin
            pend_reg <= emit_res;
        end else if (cmd.reply) begin
            pend_reg <= reply_res;
        end
        if (xfer) begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg      <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                found_reg <= 1'b0;
                n_reg     <= '0;
            end else if (cmd.step) begin
                found_reg <= found_next;
                if (emit) begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            if ((cmd.step && emit) || cmd.reply) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (xfer) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.emit        = emit;
    assign sts.pend_valid  = pend_valid_reg;
    assign sts.out_free    = out_free;
    assign sts.needs_reply = (act_reg == ACT_ADD) || (act_reg == ACT_LOOKUP);

    assign out_result = out_reg;
    assign out_last   = out_last_reg;
    assign out_valid  = out_valid_reg;

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= CNT_W'(MAX_RESULTS))
        else $error("result count beyond limit");
    a_xfer_free: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer |-> out_free)
        else $error("output register overwritten while stalled");
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |=> out_valid_reg && out_last_reg && !pend_valid_reg)
        else $error("final result not marked last");

endmodule
`default_nettype wire

FILE: hdl/tick_task_scheduler_table.sv
// top level of the tick task scheduler table
//
//  channel | dir | tdata (low bit up)                                       | tuser     | tlast
//  s_      | in  | slot_select, first_delay, repeat_period, cooperative, tag | action    | -
//  m_      | out | slot, tag_out, overrun                                   | kind      | last
//
//  each request runs through these steps, plus stalls: an intake step, then
//  the controller walks the slot table one slot per cycle unless the m_ side
//  stalls it, then add and lookup place their reply, then any final result is flushed.
//  a new request is taken only once the previous one's last result is in the
//  output register. a stalled m_ side holds the walk at the next emitting slot.
//  synchronous active-low reset frees every slot; no clearing pass is needed.
`default_nettype none
module tick_task_scheduler_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // slot_select, first_delay, repeat_period, cooperative, task_tag
    input  wire logic [2:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // slot, tag_out, overrun
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast
);
    import ttst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;
    result_t    res;

    ttst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ttst_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .req_action        (s_tuser),
        .req_slot_select   (s_tdata[2:0]),
        .req_first_delay   (s_tdata[10:3]),
        .req_repeat_period (s_tdata[18:11]),
        .req_cooperative   (s_tdata[19]),
        .req_task_tag      (s_tdata[27:20]),
        .out_result        (res),
        .out_last          (m_tlast),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready)
    );

    assign m_tdata = {3'b000, res.overrun, res.tag, res.slot};
    assign m_tuser = res.kind;

endmodule
`default_nettype wire
